// ===== rtl/sprs_pkg.sv =====
package sprs_pkg;

  localparam int IDX_W  = 48;
  localparam int BODY_W = 64;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] KEEP_RESET = 7'd64;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_RANGE  = 3'd2;
  localparam logic [2:0] ACT_CLEAR  = 3'd3;
  localparam logic [2:0] ACT_DROP   = 3'd4;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_REC  = 2'd1;
  localparam logic [1:0] KIND_MISS = 2'd2;
  localparam logic [1:0] KIND_CTRL = 2'd3;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CW    = 3;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_RANGE  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_DROP   = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [BODY_W-1:0] payload;
    logic              raw_present;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  end_index;
  } item_t;

  typedef struct packed {
    op_t               op;
    logic [BODY_W-1:0] payload;
    logic              raw_present;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  end_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  seq_index;
    logic [BODY_W-1:0] payload_out;
    logic              has_raw;
    logic              evicted;
    logic [IDX_W-1:0]  evicted_index;
    logic              last;
    logic [CNT_W-1:0]  held_count;
    logic [IDX_W-1:0]  oldest_index;
    logic [IDX_W-1:0]  newest_index;
  } result_t;

endpackage

// ===== rtl/sequenced_packet_ring_store.sv =====
// Channel   Ports                        Beat taken when
// -------   --------------------------   ---------------------
// item      push, full, item             push && !full
// result    empty, pop, result           pop && !empty
// config    cfg_we, cfg_data             cfg_we
//
// Push, lookup, clear and drop-all each fire once in the back end, so one item
// per cycle is sustained while the result queue has room; an item's first result
// goes through the front queue, result register and result queue to the ports.
// A range lookup returns one record per cycle while the result queue has room,
// paced by the single ring memory read port, and holds commands until its last record.
// Reset clears the counters and raw flags at once; there is no clearing pass.
// A full result queue stalls the back end, and a full command queue raises full.
module sequenced_packet_ring_store import sprs_pkg::*; #(
  parameter int DEPTH    = 64,
  parameter int SEQ_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  item_t            item,
  output logic             empty,
  input  logic             pop,
  output result_t          result,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;
  logic               res_valid;
  result_t            res;
  logic [OUTQ_CW-1:0] q_count;

  sprs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  sprs_back #(
    .DEPTH    (DEPTH),
    .SEQ_BITS (SEQ_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .q_count   (q_count),
    .res_valid (res_valid),
    .res       (res)
  );

  sprs_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .pop     (pop),
    .empty   (empty),
    .rd_data (result),
    .count   (q_count)
  );

endmodule

// ===== rtl/sprs_front.sv =====
module sprs_front import sprs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_ready
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       known;
  op_t        op;
  logic       enq;
  logic       deq;

  // Actions outside the defined set are dropped here and never reach the back end.
  always_comb begin
    known = 1'b1;
    op    = OP_PUSH;
    unique case (item.action)
      ACT_PUSH:   op = OP_PUSH;
      ACT_LOOKUP: op = OP_LOOKUP;
      ACT_RANGE:  op = OP_RANGE;
      ACT_CLEAR:  op = OP_CLEAR;
      ACT_DROP:   op = OP_DROP;
      default:    known = 1'b0;
    endcase
  end

  assign full      = (count == 2'd2);
  assign enq       = push && !full && known;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign deq       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      if (enq && !deq) begin
        count <= count + 2'd1;
      end else if (deq && !enq) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      entries[wr_ptr] <= '{op:          op,
                           payload:     item.payload,
                           raw_present: item.raw_present,
                           first_index: item.first_index,
                           end_index:   item.end_index};
    end
  end

endmodule

// ===== rtl/sprs_back.sv =====
module sprs_back import sprs_pkg::*; #(
  parameter int DEPTH    = 64,
  parameter int SEQ_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_data,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_ready,
  input  logic [OUTQ_CW-1:0] q_count,
  output logic               res_valid,
  output result_t            res
);

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (SEQ_BITS > IDX_W) ? SEQ_BITS : IDX_W;

  typedef enum logic [1:0] {
    ST_CMD   = 2'b01,
    ST_RANGE = 2'b10
  } back_state_t;

  back_state_t          st;
  logic [SEQ_BITS-1:0]  total;
  logic [SEQ_BITS-1:0]  oldest;
  logic [SEQ_BITS-1:0]  newest;
  logic [CNT_W-1:0]     held;
  logic [SW-1:0]        wr_slot;
  logic [DEPTH-1:0]     raw_flag;
  logic [CNT_W-1:0]     keep_raw_count;

  logic [SEQ_BITS-1:0]  seq_mem  [DEPTH];
  logic [BODY_W-1:0]    body_mem [DEPTH];
  logic [SEQ_BITS-1:0]  rd_seq;
  logic [BODY_W-1:0]    rd_body;
  logic [SW-1:0]        rd_addr;
  logic                 mem_we;

  logic [SW-1:0]        rng_slot;
  logic [IDX_W-1:0]     rng_seq;
  logic [CNT_W-1:0]     rng_left;

  logic                 r_valid;
  logic [1:0]           r_kind;
  logic [IDX_W-1:0]     r_seq;
  logic                 r_has_raw;
  logic                 r_evicted;
  logic                 r_last;
  logic [BODY_W-1:0]    r_payload;

  logic                 space;
  logic                 fire_cmd;
  logic                 fire_rng;
  logic                 wrap;
  logic [CW-1:0]        total_c;
  logic [CW-1:0]        oldest_c;
  logic [CW-1:0]        first_c;
  logic [CW-1:0]        end_c;
  logic [CW-1:0]        lo_c;
  logic [CW-1:0]        hi_c;
  logic [CW-1:0]        sel_c;
  logic [CW-1:0]        dist_full;
  logic [CW-1:0]        span_full;
  logic [CNT_W-1:0]     span;
  logic [CNT_W-1:0]     keep;
  logic                 win_hit;
  logic                 rng_nonempty;
  logic [SW:0]          look_sum;
  logic [SW:0]          clr_sum;
  logic [SW-1:0]        look_slot;
  logic [SW-1:0]        clr_slot;
  logic [SW-1:0]        wr_slot_next;
  logic [SW-1:0]        look_slot_next;
  logic [SW-1:0]        rng_slot_next;
  logic [DEPTH-1:0]     raw_push;

  logic [1:0]           e_kind;
  logic [IDX_W-1:0]     e_seq;
  logic                 e_has_raw;
  logic                 e_evicted;
  logic                 e_last;

  // The result stage never stalls: a command only fires when the queue has room for it.
  assign space     = (q_count + OUTQ_CW'(r_valid)) < OUTQ_CW'(OUTQ_DEPTH);
  assign cmd_ready = (st == ST_CMD) && space;
  assign fire_cmd  = cmd_ready && cmd_valid;
  assign fire_rng  = (st == ST_RANGE) && space;
  assign wrap      = &total;

  always_comb begin
    total_c      = CW'(total);
    oldest_c     = CW'(oldest);
    first_c      = CW'(cmd.first_index);
    end_c        = CW'(cmd.end_index);
    win_hit      = (first_c < total_c) && (first_c >= oldest_c);
    lo_c         = (first_c < oldest_c) ? oldest_c : first_c;
    hi_c         = (end_c > total_c) ? total_c : end_c;
    rng_nonempty = (lo_c < hi_c);
    span_full    = hi_c - lo_c;
    span         = span_full[CNT_W-1:0];
    sel_c        = (cmd.op == OP_RANGE) ? lo_c : first_c;

    // Inside the window the distance back from the newest record is below DEPTH,
    // so the slot follows from the write pointer with one wrap correction.
    dist_full = total_c - sel_c - CW'(1);
    look_sum  = (SW+1)'(wr_slot)
              + ((SW+1)'(DEPTH - 1) - (SW+1)'(dist_full[CNT_W-1:0]));
    look_slot = (look_sum >= (SW+1)'(DEPTH)) ? SW'(look_sum - (SW+1)'(DEPTH))
                                             : SW'(look_sum);

    keep     = (keep_raw_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : keep_raw_count;
    clr_sum  = (SW+1)'(wr_slot) + ((SW+1)'(DEPTH) - (SW+1)'(keep));
    clr_slot = (clr_sum >= (SW+1)'(DEPTH)) ? SW'(clr_sum - (SW+1)'(DEPTH))
                                           : SW'(clr_sum);

    wr_slot_next   = (wr_slot == SW'(DEPTH - 1)) ? '0 : wr_slot + 1'b1;
    look_slot_next = (look_slot == SW'(DEPTH - 1)) ? '0 : look_slot + 1'b1;
    rng_slot_next  = (rng_slot == SW'(DEPTH - 1)) ? '0 : rng_slot + 1'b1;

    raw_push = raw_flag;
    if (total_c >= CW'(keep)) begin
      raw_push[clr_slot] = 1'b0;
    end
    raw_push[wr_slot] = cmd.raw_present;
  end

  always_comb begin
    e_kind    = KIND_CTRL;
    e_seq     = '0;
    e_has_raw = 1'b0;
    e_evicted = 1'b0;
    e_last    = 1'b1;
    if (st == ST_RANGE) begin
      e_kind    = KIND_REC;
      e_seq     = rng_seq;
      e_has_raw = raw_flag[rng_slot];
      e_last    = (rng_left == CNT_W'(1));
    end else begin
      unique case (cmd.op)
        OP_PUSH: begin
          e_kind    = KIND_PUSH;
          e_seq     = IDX_W'(total);
          e_has_raw = cmd.raw_present;
          e_evicted = raw_flag[wr_slot];
        end
        OP_LOOKUP: begin
          e_kind    = win_hit ? KIND_REC : KIND_MISS;
          e_seq     = cmd.first_index;
          e_has_raw = win_hit && raw_flag[look_slot];
        end
        OP_RANGE: begin
          e_kind    = rng_nonempty ? KIND_REC : KIND_MISS;
          e_seq     = IDX_W'(lo_c);
          e_has_raw = rng_nonempty && raw_flag[look_slot];
          e_last    = !rng_nonempty || (span == CNT_W'(1));
        end
        default: begin
          e_kind = KIND_CTRL;
        end
      endcase
    end
  end

  assign mem_we  = fire_cmd && (cmd.op == OP_PUSH);
  assign rd_addr = (st == ST_RANGE) ? rng_slot :
                   (cmd.op == OP_PUSH) ? wr_slot : look_slot;

  // Read happens before the write, so a push sees the sequence number it overwrites.
  always_ff @(posedge clk) begin
    rd_seq  <= seq_mem[rd_addr];
    rd_body <= body_mem[rd_addr];
    if (mem_we) begin
      seq_mem[wr_slot]  <= total;
      body_mem[wr_slot] <= cmd.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_CMD;
      total          <= '0;
      oldest         <= '0;
      newest         <= '0;
      held           <= '0;
      wr_slot        <= '0;
      raw_flag       <= '0;
      keep_raw_count <= KEEP_RESET;
      r_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_raw_count <= cfg_data;
      end
      r_valid <= fire_cmd || fire_rng;
      if (fire_cmd) begin
        unique case (cmd.op)
          OP_PUSH: begin
            total    <= total + 1'b1;
            raw_flag <= raw_push;
            if (wrap) begin
              oldest  <= '0;
              newest  <= '0;
              held    <= '0;
              wr_slot <= '0;
            end else begin
              oldest  <= (held == CNT_W'(DEPTH)) ? oldest + 1'b1 : '0;
              newest  <= total;
              held    <= (held == CNT_W'(DEPTH)) ? held : held + 1'b1;
              wr_slot <= wr_slot_next;
            end
          end
          OP_RANGE: begin
            if (rng_nonempty && (span != CNT_W'(1))) begin
              st <= ST_RANGE;
            end
          end
          OP_CLEAR: begin
            total    <= '0;
            oldest   <= '0;
            newest   <= '0;
            held     <= '0;
            wr_slot  <= '0;
            raw_flag <= '0;
          end
          OP_DROP: begin
            raw_flag <= '0;
          end
          default: begin
          end
        endcase
      end
      if (fire_rng && (rng_left == CNT_W'(1))) begin
        st <= ST_CMD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_cmd || fire_rng) begin
      r_kind    <= e_kind;
      r_seq     <= e_seq;
      r_has_raw <= e_has_raw;
      r_evicted <= e_evicted;
      r_last    <= e_last;
      r_payload <= cmd.payload;
    end
    if (fire_cmd) begin
      rng_slot <= look_slot_next;
      rng_seq  <= IDX_W'(lo_c) + 1'b1;
      rng_left <= span - 1'b1;
    end else if (fire_rng) begin
      rng_slot <= rng_slot_next;
      rng_seq  <= rng_seq + 1'b1;
      rng_left <= rng_left - 1'b1;
    end
  end

  // Status fields are read after the update made by the item in this stage.
  assign res_valid = r_valid;
  always_comb begin
    res.kind          = r_kind;
    res.seq_index     = r_seq;
    res.payload_out   = (r_kind == KIND_PUSH) ? r_payload :
                        (r_kind == KIND_REC) ? rd_body : '0;
    res.has_raw       = r_has_raw;
    res.evicted       = r_evicted;
    res.evicted_index = r_evicted ? IDX_W'(rd_seq) : '0;
    res.last          = r_last;
    res.held_count    = held;
    res.oldest_index  = IDX_W'(oldest);
    res.newest_index  = IDX_W'(newest);
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("held count above ring depth");

  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest != '0) |-> (held == CNT_W'(DEPTH)))
    else $error("oldest index moved before the ring filled");

  a_range_left: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RANGE) |-> (rng_left != '0))
    else $error("range walk with no beats left");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (q_count < OUTQ_CW'(OUTQ_DEPTH)))
    else $error("result stage wrote into a full queue");

  a_range_blocks: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RANGE) |-> !cmd_ready)
    else $error("command taken during a range walk");

endmodule

// ===== rtl/sprs_out_queue.sv =====
module sprs_out_queue import sprs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  result_t            wr_data,
  input  logic               pop,
  output logic               empty,
  output result_t            rd_data,
  output logic [OUTQ_CW-1:0] count
);

  localparam int PW = $clog2(OUTQ_DEPTH);

  result_t       entries [OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          deq;

  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];
  assign deq     = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule
